[rtl/gflnp_pkg.sv]
// constants, codes and the handle locator for the growing node pool
package gflnp_pkg;

    localparam int INIT_NODES   = 64;
    localparam int REGION_COUNT = 8;

    localparam int HANDLE_W = 13;
    localparam int COUNT_W  = 14;
    localparam int REGION_W = 3;
    localparam int OFFSET_W = 24;
    localparam int NB_W     = 13;
    localparam int PROD_W   = HANDLE_W + COUNT_W;

    localparam int STACK_DEPTH = 1 << HANDLE_W;
    localparam int RAW_CAP     = INIT_NODES << (REGION_COUNT - 1);
    localparam int POOL_CAP    = (RAW_CAP > STACK_DEPTH) ? STACK_DEPTH : RAW_CAP;
    localparam int NB_RESET    = 16;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_RESET = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOCATE,
        S_MULT
    } state_t;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [HANDLE_W-1:0] slot;
    } loc_t;

    // region is given by the first boundary the handle lies below
    function automatic loc_t locate(input logic [HANDLE_W-1:0] h);
        loc_t res;
        logic found;
        int   base;
        found      = 1'b0;
        base       = 0;
        res.region = '0;
        for (int k = 0; k < REGION_COUNT - 1; k++)
        begin
            if (!found)
            begin
                if (int'(h) < (INIT_NODES << k))
                begin
                    found = 1'b1;
                end
                else
                begin
                    base       = INIT_NODES << k;
                    res.region = REGION_W'(k + 1);
                end
            end
        end
        res.slot = HANDLE_W'(int'(h) - base);
        return res;
    endfunction

endpackage

[rtl/gflnp_ram.sv]
// generic single-port-write, registered-read ram
module gflnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/growing_free_list_node_pool_core.sv]
// top level of the growing node pool: free stack in ram, fresh counter, offset multiplier
//
// Hands out node handles: op 0 allocates, 1 frees, 2 empties the pool, 3 does nothing,
// and every item gives exactly one result. Freed handles sit on a LIFO stack held in
// an 8192 x 13 ram and are reissued first; with the stack empty, unused handles come
// out in ascending order until the pool capacity is reached. An accepted item moves
// through the read state, which takes the stack ram output or the fresh handle, the
// locate state, which finds the handle's region and slot, and the multiply state,
// which forms slot times node size and stalls while the output is held; no new item
// is taken before the result is loaded. A finished result waits in its own register
// while the next item runs. node_bytes may be written only while the block is idle;
// the stack ram needs no clearing pass after reset.
module growing_free_list_node_pool_core
    import gflnp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [HANDLE_W-1:0] free_handle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [HANDLE_W-1:0] handle,
    output logic [REGION_W-1:0] region,
    output logic [OFFSET_W-1:0] byte_offset,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [NB_W-1:0]     cfg_data
);

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  stack_count_reg, stack_count_next;
    logic [COUNT_W-1:0]  next_fresh_reg, next_fresh_next;
    logic [NB_W-1:0]     node_bytes_reg;
    logic                out_valid_reg, out_valid_next;

    logic [1:0]          pend_status_reg;
    logic                alloc_ok_reg;
    logic                from_stack_reg;
    logic [HANDLE_W-1:0] fresh_handle_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [REGION_W-1:0] region_reg;
    logic [HANDLE_W-1:0] slot_reg;

    logic [1:0]          out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [REGION_W-1:0] out_region_reg;
    logic [OFFSET_W-1:0] out_offset_reg;

    logic                accept;
    logic                load_out;
    logic                ram_we;
    logic [HANDLE_W-1:0] ram_waddr;
    logic [HANDLE_W-1:0] ram_raddr;
    logic [HANDLE_W-1:0] ram_rdata;
    logic [1:0]          acc_status;
    logic                acc_ok;
    logic                acc_from_stack;
    loc_t                loc;
    logic [COUNT_W-1:0]  nb_sum;
    logic [COUNT_W-1:0]  eff_bytes;
    logic [PROD_W-1:0]   product;

    gflnp_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (free_handle),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   state_next = in_valid ? S_READ : S_IDLE;
            S_READ:   state_next = S_LOCATE;
            S_LOCATE: state_next = S_MULT;
            S_MULT:   state_next = load_out ? S_IDLE : S_MULT;
            default:  state_next = S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        load_out = (state_reg == S_MULT) && (!out_valid_reg || out_ready);
    end

    assign accept = in_valid && in_ready;

    // stack and fresh counter updates at acceptance
    always_comb
    begin
        stack_count_next = stack_count_reg;
        next_fresh_next  = next_fresh_reg;
        ram_we           = 1'b0;
        ram_waddr        = stack_count_reg[HANDLE_W-1:0];
        ram_raddr        = HANDLE_W'(stack_count_reg - COUNT_W'(1));
        acc_status       = STAT_OK;
        acc_ok           = 1'b0;
        acc_from_stack   = 1'b0;
        if (accept)
        begin
            case (op_t'(op))
                OP_ALLOC:
                begin
                    if (stack_count_reg != '0)
                    begin
                        stack_count_next = stack_count_reg - COUNT_W'(1);
                        acc_ok           = 1'b1;
                        acc_from_stack   = 1'b1;
                    end
                    else if (next_fresh_reg < COUNT_W'(POOL_CAP))
                    begin
                        next_fresh_next = next_fresh_reg + COUNT_W'(1);
                        acc_ok          = 1'b1;
                    end
                    else
                    begin
                        acc_status = STAT_EXHAUSTED;
                    end
                end
                OP_FREE:
                begin
                    if (stack_count_reg >= COUNT_W'(STACK_DEPTH))
                    begin
                        acc_status = STAT_FULL;
                    end
                    else
                    begin
                        ram_we           = 1'b1;
                        stack_count_next = stack_count_reg + COUNT_W'(1);
                    end
                end
                OP_RESET:
                begin
                    stack_count_next = '0;
                    next_fresh_next  = '0;
                end
                default:
                begin
                    acc_status = STAT_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stack_count_reg <= '0;
            next_fresh_reg  <= '0;
            node_bytes_reg  <= NB_W'(NB_RESET);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stack_count_reg <= stack_count_next;
            next_fresh_reg  <= next_fresh_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                node_bytes_reg <= cfg_data;
            end
        end
    end

    assign loc = locate(handle_reg);

    // node size rounded up to a multiple of eight, at least eight
    always_comb
    begin
        nb_sum    = COUNT_W'(node_bytes_reg) + COUNT_W'(7);
        eff_bytes = {nb_sum[COUNT_W-1:3], 3'b000};
        if (eff_bytes == '0)
        begin
            eff_bytes = COUNT_W'(8);
        end
        product = PROD_W'(slot_reg) * PROD_W'(eff_bytes);
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg  <= acc_status;
            alloc_ok_reg     <= acc_ok;
            from_stack_reg   <= acc_from_stack;
            fresh_handle_reg <= next_fresh_reg[HANDLE_W-1:0];
        end
        if (state_reg == S_READ)
        begin
            handle_reg <= from_stack_reg ? ram_rdata : fresh_handle_reg;
        end
        if (state_reg == S_LOCATE)
        begin
            region_reg <= loc.region;
            slot_reg   <= loc.slot;
        end
        if (load_out)
        begin
            out_status_reg <= pend_status_reg;
            out_handle_reg <= alloc_ok_reg ? handle_reg : '0;
            out_region_reg <= alloc_ok_reg ? region_reg : '0;
            out_offset_reg <= alloc_ok_reg ? product[OFFSET_W-1:0] : '0;
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign handle      = out_handle_reg;
    assign region      = out_region_reg;
    assign byte_offset = out_offset_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_count_reg <= COUNT_W'(STACK_DEPTH))
        else $error("free stack count beyond depth");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_fresh_reg <= COUNT_W'(POOL_CAP))
        else $error("fresh counter beyond pool capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (handle == '0 && byte_offset == '0))
        else $error("failed item carries a handle");

    a_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_READ) ##1 (state_reg == S_LOCATE))
        else $error("item did not advance through read and locate");

endmodule
